/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is active.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

/* sv/bdq_pkg.sv */
// Types, constants and address helpers for the bounded deque.
package bdq_pkg;

    localparam int CAPACITY    = 256;
    localparam int ENTRY_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed widths of the channel fields
    localparam int ENTRY_IO_W  = 32;
    localparam int POS_W       = 8;
    localparam int FILL_W      = 9;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_RM_HEAD  = 3'd2,
        OP_RM_TAIL  = 3'd3,
        OP_RD_HEAD  = 3'd4,
        OP_RD_TAIL  = 3'd5,
        OP_RD_INDEX = 3'd6,
        OP_CLEAR    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                  kind;
        logic [ENTRY_IO_W-1:0]  entry_in;
        logic [POS_W-1:0]       position;
    } req_t;

    typedef struct packed {
        logic [ENTRY_IO_W-1:0]  entry_out;
        logic [FILL_W-1:0]      fill_count;
        status_t                status;
    } rsp_t;

    // Result waiting for the RAM read data
    typedef struct packed {
        logic                   valid;
        logic                   use_rdata;
        logic [CNT_W-1:0]       fill;
        status_t                status;
    } pend_t;

    // Write and read port signals for the RAM
    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [ENTRY_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
    } mem_req_t;

    // Slot that holds list position pos, wrapped around the ring
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

/* sv/bdq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/bdq_ctrl.sv */
// Head pointer, fill count and RAM access for each deque request.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  req_t     req,
    input  logic     pend_take,
    output pend_t    pend,
    output mem_req_t mem_req
);

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    pend_t             pend_reg, pend_next;

    logic              acc;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  pos_sel;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] tail_addr;
    pend_t             res;
    mem_req_t          mem;

    // Take a new request when no result is pending or the pending result leaves
    assign req_ready = !pend_reg.valid || pend_take;
    assign acc       = req_valid && req_ready;

    assign full      = (occ_reg == CNT_W'(CAPACITY));
    assign empty     = (occ_reg == '0);
    assign head_dec  = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign tail_addr = slot_of(head_reg, occ_reg);

    // Pick the list position a read goes to
    always_comb
    begin
        case (req.kind)
            OP_RD_HEAD: pos_sel = '0;
            OP_RD_TAIL: pos_sel = occ_reg - 1'b1;
            default:    pos_sel = CNT_W'(req.position);
        endcase
    end

    // Decode the request into pointer updates, RAM access and status
    always_comb
    begin
        head_next     = head_reg;
        occ_next      = occ_reg;
        res.valid     = 1'b1;
        res.use_rdata = 1'b0;
        res.status    = ST_OK;
        mem.wr_en     = 1'b0;
        mem.wr_addr   = tail_addr;
        mem.wr_data   = req.entry_in[ENTRY_WIDTH-1:0];
        mem.rd_en     = 1'b0;
        mem.rd_addr   = slot_of(head_reg, pos_sel);

        case (req.kind)
            OP_INS_HEAD, OP_INS_TAIL:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    mem.wr_en = 1'b1;
                    occ_next  = occ_reg + 1'b1;
                    if (req.kind == OP_INS_HEAD)
                    begin
                        head_next   = head_dec;
                        mem.wr_addr = head_dec;
                    end
                end
            end
            OP_RM_HEAD, OP_RM_TAIL:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    occ_next = occ_reg - 1'b1;
                    if (req.kind == OP_RM_HEAD)
                    begin
                        head_next = head_inc;
                    end
                end
            end
            OP_RD_HEAD, OP_RD_TAIL, OP_RD_INDEX:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else if (pos_sel >= occ_reg)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    mem.rd_en     = 1'b1;
                    res.use_rdata = 1'b1;
                end
            end
            default:
            begin
                occ_next = '0;
            end
        endcase

        res.fill = occ_next;

        // Drop everything unless the request is accepted
        if (!acc)
        begin
            head_next = head_reg;
            occ_next  = occ_reg;
            mem.wr_en = 1'b0;
            mem.rd_en = 1'b0;
        end
    end

    // Load a new pending result, or drain the current one
    always_comb
    begin
        pend_next = pend_reg;
        if (acc)
        begin
            pend_next = res;
        end
        else if (pend_take)
        begin
            pend_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            pend_reg <= pend_next;
        end
    end

    assign pend    = pend_reg;
    assign mem_req = mem;

endmodule

/* sv/bounded_deque_array_list.sv */
// Top level of the bounded deque: control, slot RAM and response register.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  request | req_valid / req_ready  | req : kind, entry_in, position
//  reply   | rsp_valid / rsp_ready  | rsp : entry_out, fill_count, status
//
// Sustains one request per cycle while replies are taken; the slot RAM read and
// the pending result register load at the edge that accepts a request, and the
// reply register loads from them once it is free.
// Reset clears the head pointer, fill count and both valid stages; the slot
// RAM is not cleared and needs no sweep, the fill count guards every read.
// A stalled reply holds in its register; one more request is taken and waits
// behind it, then req_ready drops until rsp_ready returns.
module bounded_deque_array_list
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    pend_t                  pend;
    mem_req_t               mem_req;
    logic                   pend_take;
    logic [ENTRY_WIDTH-1:0] rd_data;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pend_take (pend_take),
        .pend      (pend),
        .mem_req   (mem_req)
    );

    bdq_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    // Advance the pending result when the reply register is free
    assign pend_take = pend.valid && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (pend_take)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.entry_out  = pend.use_rdata ? ENTRY_IO_W'(rd_data) : '0;
            rsp_next.fill_count = FILL_W'(pend.fill);
            rsp_next.status     = pend.status;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Hold the reply until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* sv/bdq_checker.sv */
// Port-level checks for the bounded deque, bound to the top level.
`include "assert_macros.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // Hold a stalled reply
    `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "reply changed while stalled")

    // Fill count never passes the capacity
    `ASSERT_NEVER(a_fill_bound, rsp_valid && (rsp.fill_count > FILL_W'(CAPACITY)), "fill count above capacity")

    // Any error reply carries a zero entry
    `ASSERT_NEVER(a_err_zero, rsp_valid && (rsp.status != ST_OK) && (rsp.entry_out != '0), "error reply with nonzero entry")

    // A dropped insert only happens at full capacity
    `ASSERT_NEVER(a_full_fill, rsp_valid && (rsp.status == ST_FULL) && (rsp.fill_count != FILL_W'(CAPACITY)), "full status below capacity")

    // An empty status only comes from an empty list
    `ASSERT_NEVER(a_empty_fill, rsp_valid && (rsp.status == ST_EMPTY) && (rsp.fill_count != '0), "empty status with entries held")

endmodule

bind bounded_deque_array_list bdq_checker u_bdq_checker (.*);
